### src/pqt_pkg.sv
// Package for the prefix query tokenizer: token kinds, scan modes, keyword
// constants and the per-byte lexer step functions.
// No dependencies.
package pqt_pkg;

   typedef enum logic [1:0] {
      MODE_SKIP   = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_TOKEN  = 2'd2,
      MODE_ESCAPE = 2'd3
   } scan_mode_type;

   typedef enum logic [3:0] {
      KIND_END      = 4'd0,
      KIND_TERM     = 4'd1,
      KIND_AND      = 4'd2,
      KIND_OR       = 4'd3,
      KIND_NOT      = 4'd4,
      KIND_ATTR     = 4'd5,
      KIND_SET      = 4'd6,
      KIND_ATTRSET  = 4'd7,
      KIND_PROX     = 4'd8,
      KIND_TERMTYPE = 4'd9
   } token_kind_type;

   typedef enum logic [2:0] {
      CSR_ESC_BYTE      = 3'd0,
      CSR_OPEN_QUOTE_A  = 3'd1,
      CSR_CLOSE_QUOTE_A = 3'd2,
      CSR_OPEN_QUOTE_B  = 3'd3,
      CSR_CLOSE_QUOTE_B = 3'd4
   } csr_index_type;

   localparam logic [7:0]  BYTE_NUL       = 8'd0;
   localparam logic [7:0]  BYTE_SPACE     = 8'd32;
   localparam logic [7:0]  BYTE_BACKSLASH = 8'd92;
   localparam logic [7:0]  BYTE_DIGIT_0   = 8'd48;
   localparam logic [7:0]  BYTE_DIGIT_9   = 8'd57;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam int          NUM_KEYWORDS   = 8;
   localparam int          KEYWORD_CHARS  = 7;

   // Keyword text, one byte per character, unused tail bytes are zero.
   localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KEYWORD_CHARS] = '{
      '{8'h61, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},  // and
      '{8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // or
      '{8'h6E, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},  // not
      '{8'h61, 8'h74, 8'h74, 8'h72, 8'h00, 8'h00, 8'h00},  // attr
      '{8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},  // set
      '{8'h61, 8'h74, 8'h74, 8'h72, 8'h73, 8'h65, 8'h74},  // attrset
      '{8'h70, 8'h72, 8'h6F, 8'h78, 8'h00, 8'h00, 8'h00},  // prox
      '{8'h74, 8'h65, 8'h72, 8'h6D, 8'h00, 8'h00, 8'h00}   // term
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd3, 4'd2, 4'd3, 4'd4, 4'd3, 4'd7, 4'd4, 4'd4
   };
   localparam token_kind_type KW_KIND [NUM_KEYWORDS] = '{
      KIND_AND, KIND_OR, KIND_NOT, KIND_ATTR,
      KIND_SET, KIND_ATTRSET, KIND_PROX, KIND_TERMTYPE
   };

   typedef logic [7:0][7:0] head_type;

   typedef struct packed {
      logic [7:0] esc_byte;
      logic [7:0] open_quote_a;
      logic [7:0] close_quote_a;
      logic [7:0] open_quote_b;
      logic [7:0] close_quote_b;
   } cfg_type;

   typedef struct packed {
      scan_mode_type mode;
      logic [7:0]    delim;
      logic          bs_pending;
      logic [15:0]   start;
      logic [15:0]   len;
   } tok_state_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    len;
   } result_type;

   // One write into the keyword window, at the token length before it counts up.
   typedef struct packed {
      logic        we;
      logic [15:0] idx;
      logic [7:0]  data;
   } win_write_type;

   typedef struct packed {
      tok_state_type       st;
      logic [1:0]          n_res;
      result_type [1:0]    res;
      logic [1:0]          n_wr;
      win_write_type [1:0] wr;
      logic                query_end;
   } step_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    len;
      logic           last;
   } out_word_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   // The token is a keyword only when it is the escape byte followed by
   // exactly the whole keyword.
   function automatic token_kind_type classify(input head_type head,
                                               input logic [15:0] len,
                                               input logic [7:0] esc);
      token_kind_type k;
      logic           hit;
      k = KIND_TERM;
      if (head[0] == esc) begin
         for (int i = 0; i < NUM_KEYWORDS; i++) begin
            hit = (len == {12'd0, KW_LEN[i]} + 16'd1);
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
               if ((4'(j) < KW_LEN[i]) && (head[j + 1] != KW_TEXT[i][j])) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               k = KW_KIND[i];
            end
         end
      end
      return k;
   endfunction

   function automatic step_type put_result(input step_type c, input token_kind_type k,
                                           input logic [15:0] s, input logic [15:0] l);
      step_type r;
      r = c;
      if (c.n_res == 2'd0) begin
         r.res[0] = '{kind: k, start: s, len: l};
         r.n_res  = 2'd1;
      end else if (c.n_res == 2'd1) begin
         r.res[1] = '{kind: k, start: s, len: l};
         r.n_res  = 2'd2;
      end
      return r;
   endfunction

   function automatic step_type clear_token(input step_type c);
      step_type r;
      r = c;
      r.st.mode       = MODE_SKIP;
      r.st.delim      = BYTE_SPACE;
      r.st.bs_pending = 1'b0;
      r.st.len        = 16'd0;
      return r;
   endfunction

   function automatic step_type finish_token(input step_type c, input head_type head,
                                             input logic [7:0] esc);
      step_type r;
      r = put_result(c, classify(head, c.st.len, esc), c.st.start, c.st.len);
      return clear_token(r);
   endfunction

   function automatic step_type finish_query(input step_type c, input logic [15:0] cur);
      step_type r;
      r = put_result(c, KIND_END, cur, 16'd0);
      r = clear_token(r);
      r.query_end = 1'b1;
      return r;
   endfunction

   function automatic step_type take_byte(input step_type c, input logic [7:0] b);
      step_type r;
      r = c;
      if (c.n_wr == 2'd0) begin
         r.wr[0] = '{we: 1'b1, idx: c.st.len, data: b};
         r.n_wr  = 2'd1;
      end else begin
         r.wr[1] = '{we: 1'b1, idx: c.st.len, data: b};
         r.n_wr  = 2'd2;
      end
      r.st.len = sat_inc(c.st.len);
      return r;
   endfunction

   function automatic step_type in_token(input step_type c, input logic [7:0] b,
                                         input logic [15:0] cur, input head_type head,
                                         input logic [7:0] esc);
      step_type r;
      r = c;
      if (c.st.bs_pending) begin
         r.st.bs_pending = 1'b0;
         if (b == BYTE_NUL) begin
            r = finish_token(r, head, esc);
            r = finish_query(r, cur);
         end else begin
            r = take_byte(r, b);
         end
      end else if (b == BYTE_NUL) begin
         r = finish_token(r, head, esc);
         r = finish_query(r, cur);
      end else if (b == c.st.delim) begin
         r = finish_token(r, head, esc);
      end else begin
         r = take_byte(r, b);
         if (b == BYTE_BACKSLASH) begin
            r.st.bs_pending = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic step_type token_begin(input step_type c, input logic [7:0] b,
                                            input logic [15:0] cur,
                                            input logic [15:0] pos_inc,
                                            input head_type head, input cfg_type cfg);
      step_type r;
      r = c;
      if (b == BYTE_SPACE) begin
         r = c;
      end else if (b == BYTE_NUL) begin
         r = finish_query(r, cur);
      end else begin
         r.st.len        = 16'd0;
         r.st.bs_pending = 1'b0;
         if ((b == cfg.open_quote_a) || (b == cfg.open_quote_b)) begin
            // Pair a wins when both opening registers match.
            r.st.delim = (b == cfg.open_quote_a) ? cfg.close_quote_a : cfg.close_quote_b;
            r.st.start = pos_inc;
            r.st.mode  = MODE_FIRST;
         end else begin
            r.st.delim = BYTE_SPACE;
            r.st.start = cur;
            if (b == cfg.esc_byte) begin
               r.st.mode = MODE_ESCAPE;
            end else begin
               r.st.mode = MODE_TOKEN;
               r = in_token(r, b, cur, head, cfg.esc_byte);
            end
         end
      end
      return r;
   endfunction

   // Full lexer step for one query byte.
   function automatic step_type tok_step(input tok_state_type st, input logic [7:0] b,
                                         input logic [15:0] cur, input head_type head,
                                         input cfg_type cfg);
      step_type   r;
      logic [15:0] pos_inc;
      r          = '0;
      r.st       = st;
      pos_inc    = sat_inc(cur);
      case (st.mode)
         MODE_SKIP: begin
            r = token_begin(r, b, cur, pos_inc, head, cfg);
         end
         MODE_FIRST: begin
            if ((b != BYTE_NUL) && (b == cfg.esc_byte)) begin
               r.st.mode = MODE_ESCAPE;
            end else begin
               r.st.mode = MODE_TOKEN;
               r = in_token(r, b, cur, head, cfg.esc_byte);
            end
         end
         MODE_TOKEN: begin
            r = in_token(r, b, cur, head, cfg.esc_byte);
         end
         default: begin
            if ((b >= BYTE_DIGIT_0) && (b <= BYTE_DIGIT_9)) begin
               // Attribute shorthand: escape plus digit, the digit opens a new token.
               r = put_result(r, KIND_ATTR, st.start, 16'd1);
               r = clear_token(r);
               r = token_begin(r, b, cur, pos_inc, head, cfg);
            end else begin
               r.st.mode = MODE_TOKEN;
               r = in_token(r, cfg.esc_byte, cur, head, cfg.esc_byte);
               if (r.st.mode == MODE_SKIP) begin
                  r = token_begin(r, b, cur, pos_inc, head, cfg);
               end else begin
                  r = in_token(r, b, cur, head, cfg.esc_byte);
               end
            end
         end
      endcase
      return r;
   endfunction

endpackage

### src/prefix_query_tokenizer.sv
// Prefix query tokenizer top level: scan state, keyword window, config
// registers and a four-word result queue. Depends on pqt_pkg.
//
// A result word is written into the result queue when its byte is accepted, and is offered on rsp from there.
// One query byte is taken per cycle while req_tready is high; a byte that ends a token and
// the query yields two words. The rsp port drains one word per cycle from the queue
// while rsp_tready is high; req_tready drops while the result queue holds more than two words.
// Reset is synchronous: scan state, position, queue and config return to defaults.
module prefix_query_tokenizer
   import pqt_pkg::*;
#(
   parameter int KEYWORD_WINDOW = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Query byte input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] query_byte
   // Token output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] token_start, [31:16] token_length
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast,   // last_of_run
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int WIN_IDX_W = $clog2(KEYWORD_WINDOW);

   cfg_type       cfg_ff;
   tok_state_type tok_st_ff, tok_st_in;
   logic [15:0]   position_ff, position_in;
   logic [7:0]    window_ff [KEYWORD_WINDOW];
   head_type      head;
   step_type      step;
   logic          accept;

   out_word_type  queue_ff [4];
   logic [1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [2:0]    count_ff, count_in;
   logic          pop;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         head[i] = window_ff[WIN_IDX_W'(i)];
      end
   end

   assign step        = tok_step(tok_st_ff, req_tdata, position_ff, head, cfg_ff);
   assign tok_st_in   = step.st;
   assign position_in = step.query_end ? 16'd0 : sat_inc(position_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{esc_byte: 8'd64, open_quote_a: 8'd123, close_quote_a: 8'd125,
                     open_quote_b: 8'd34, close_quote_b: 8'd34};
      end else if (csr_we) begin
         case (csr_index)
            CSR_ESC_BYTE:      cfg_ff.esc_byte      <= csr_wdata;
            CSR_OPEN_QUOTE_A:  cfg_ff.open_quote_a  <= csr_wdata;
            CSR_CLOSE_QUOTE_A: cfg_ff.close_quote_a <= csr_wdata;
            CSR_OPEN_QUOTE_B:  cfg_ff.open_quote_b  <= csr_wdata;
            CSR_CLOSE_QUOTE_B: cfg_ff.close_quote_b <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_st_ff   <= '{mode: MODE_SKIP, delim: BYTE_SPACE, bs_pending: 1'b0,
                          start: 16'd0, len: 16'd0};
         position_ff <= 16'd0;
      end else if (accept) begin
         tok_st_ff   <= tok_st_in;
         position_ff <= position_in;
      end
   end

   // Only entries below the current token length can decide a keyword match, so the
   // window needs no reset. The second write is the later one.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int w = 0; w < 2; w++) begin
            if (step.wr[w].we && (step.wr[w].idx < 16'(KEYWORD_WINDOW))) begin
               window_ff[step.wr[w].idx[WIN_IDX_W-1:0]] <= step.wr[w].data;
            end
         end
      end
   end

   // Result queue.
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign req_tready = (count_ff <= 3'd2);

   always_comb begin
      count_in = count_ff - {2'd0, pop};
      if (accept) begin
         count_in = count_in + {1'b0, step.n_res};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (step.n_res != 2'd0) begin
            queue_ff[wr_ptr_ff] <= '{kind: step.res[0].kind, start: step.res[0].start,
                                     len: step.res[0].len, last: (step.n_res == 2'd1)};
         end
         if (step.n_res == 2'd2) begin
            queue_ff[wr_ptr_ff + 2'd1] <= '{kind: step.res[1].kind,
                                            start: step.res[1].start,
                                            len: step.res[1].len, last: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + step.n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   assign rsp_tdata = {queue_ff[rd_ptr_ff].len, queue_ff[rd_ptr_ff].start};
   assign rsp_tuser = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for prefix_query_tokenizer: a directed table of query bytes, then random,
// mostly valid queries under several separator/escape configurations, checked word by
// word against a tokenizer predictor held here. Depends on pqt_pkg and the RTL top level.
module tb_top;
   import pqt_pkg::*;

   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int WINDOW_BYTES  = 8;
   localparam int PHASE_BYTES   = 145;
   localparam int TIMEOUT_NS    = 20_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [7:0]  csr_wdata = 8'd0;

   prefix_query_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the configuration registers and the scan state.
   logic [7:0]     esc_q = 8'd64;
   logic [7:0]     open_a_q = 8'd123;
   logic [7:0]     close_a_q = 8'd125;
   logic [7:0]     open_b_q = 8'd34;
   logic [7:0]     close_b_q = 8'd34;
   scan_mode_type  mode_q = MODE_SKIP;
   logic [7:0]     delim_q = BYTE_SPACE;
   logic           bs_q = 1'b0;
   logic [15:0]    pos_q = 16'd0;
   logic [15:0]    tok_start_q = 16'd0;
   logic [15:0]    tok_len_q = 16'd0;
   logic [7:0]     win_q [WINDOW_BYTES] = '{default: 8'd0};

   string          kw_names [8] = '{"and", "or", "not", "attr", "set", "attrset",
                                    "prox", "term"};
   token_kind_type kw_kinds [8] = '{KIND_AND, KIND_OR, KIND_NOT, KIND_ATTR, KIND_SET,
                                    KIND_ATTRSET, KIND_PROX, KIND_TERMTYPE};

   out_word_type   step_words [$];
   out_word_type   expected_tokens [$];
   logic [7:0]     query_bytes [$];
   int             error_count = 0;
   int             burst_left = 0;
   int             rx_cycle = 0;
   int             ready_style = 0;

   typedef struct packed {
      logic [7:0]     b;
      logic           typed;
      logic [1:0]     n;
      token_kind_type k0;
      logic [15:0]    s0;
      logic [15:0]    l0;
      token_kind_type k1;
      logic [15:0]    s1;
      logic [15:0]    l1;
   } directed_row_type;

   // Rows with typed=0 are checked against the predictor only.
   localparam directed_row_type DIRECTED_ROWS [22] = '{
      '{"@", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"2", 1'b1, 2'd1, KIND_ATTR, 16'd0, 16'd1, KIND_END, 16'd0, 16'd0},
      '{" ", 1'b1, 2'd1, KIND_TERM, 16'd1, 16'd1, KIND_END, 16'd0, 16'd0},
      '{"@", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"a", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"n", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"d", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{" ", 1'b1, 2'd1, KIND_AND, 16'd3, 16'd4, KIND_END, 16'd0, 16'd0},
      '{"{", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"}", 1'b1, 2'd1, KIND_TERM, 16'd9, 16'd0, KIND_END, 16'd0, 16'd0},
      '{8'hFF, 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{BYTE_BACKSLASH, 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{BYTE_NUL, 1'b1, 2'd2, KIND_TERM, 16'd10, 16'd2, KIND_END, 16'd12, 16'd0},
      '{BYTE_NUL, 1'b1, 2'd1, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{8'h22, 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"@", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"o", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"r", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{8'h22, 1'b1, 2'd1, KIND_OR, 16'd1, 16'd3, KIND_END, 16'd0, 16'd0},
      '{"@", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{"x", 1'b0, 2'd0, KIND_END, 16'd0, 16'd0, KIND_END, 16'd0, 16'd0},
      '{BYTE_NUL, 1'b1, 2'd2, KIND_TERM, 16'd5, 16'd2, KIND_END, 16'd7, 16'd0}
   };

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   // A keyword is the escape byte followed by exactly the whole keyword text.
   function automatic token_kind_type token_kind_of();
      token_kind_type k;
      int             n;
      bit             same;
      k = KIND_TERM;
      if (tok_len_q >= 16'd1 && tok_len_q <= 16'(WINDOW_BYTES) && win_q[0] == esc_q) begin
         n = int'(tok_len_q) - 1;
         for (int i = 0; i < 8; i++) begin
            if (kw_names[i].len() == n) begin
               same = 1'b1;
               for (int j = 0; j < n; j++) begin
                  if (win_q[j + 1] != kw_names[i][j]) same = 1'b0;
               end
               if (same) k = kw_kinds[i];
            end
         end
      end
      return k;
   endfunction

   function automatic void emit(input token_kind_type k, input logic [15:0] s,
                                input logic [15:0] l);
      if (step_words.size() < 2) step_words.push_back(out_word_type'{k, s, l, 1'b0});
   endfunction

   function automatic void close_token();
      emit(token_kind_of(), tok_start_q, tok_len_q);
      mode_q    = MODE_SKIP;
      delim_q   = BYTE_SPACE;
      bs_q      = 1'b0;
      tok_len_q = 16'd0;
   endfunction

   function automatic void close_query(input logic [15:0] cur);
      emit(KIND_END, cur, 16'd0);
      mode_q    = MODE_SKIP;
      delim_q   = BYTE_SPACE;
      bs_q      = 1'b0;
      tok_len_q = 16'd0;
      pos_q     = 16'd0;
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      if (tok_len_q < 16'(WINDOW_BYTES)) win_q[tok_len_q[2:0]] = b;
      tok_len_q = bump16(tok_len_q);
   endfunction

   function automatic void scan_in_token(input logic [7:0] b, input logic [15:0] cur);
      if (bs_q) begin
         bs_q = 1'b0;
         if (b == BYTE_NUL) begin
            close_token();
            close_query(cur);
         end else begin
            append_byte(b);
         end
      end else if (b == BYTE_NUL) begin
         close_token();
         close_query(cur);
      end else if (b == delim_q) begin
         close_token();
      end else begin
         append_byte(b);
         if (b == BYTE_BACKSLASH) bs_q = 1'b1;
      end
   endfunction

   function automatic void scan_begin(input logic [7:0] b, input logic [15:0] cur);
      if (b == BYTE_SPACE) return;
      if (b == BYTE_NUL) begin
         close_query(cur);
         return;
      end
      tok_len_q = 16'd0;
      bs_q      = 1'b0;
      if (b == open_a_q || b == open_b_q) begin
         // The separator bytes are not part of the token; pair a wins a tie.
         delim_q     = (b == open_a_q) ? close_a_q : close_b_q;
         tok_start_q = pos_q;
         mode_q      = MODE_FIRST;
         return;
      end
      delim_q     = BYTE_SPACE;
      tok_start_q = cur;
      if (b == esc_q) begin
         mode_q = MODE_ESCAPE;
         return;
      end
      mode_q = MODE_TOKEN;
      scan_in_token(b, cur);
   endfunction

   // Works out the words that one accepted byte causes, into step_words.
   function automatic void predict_byte(input logic [7:0] b);
      logic [15:0] cur;
      cur = pos_q;
      step_words.delete();
      pos_q = bump16(pos_q);
      case (mode_q)
         MODE_SKIP: begin
            scan_begin(b, cur);
         end
         MODE_FIRST: begin
            if (b != BYTE_NUL && b == esc_q) begin
               mode_q = MODE_ESCAPE;
            end else begin
               mode_q = MODE_TOKEN;
               scan_in_token(b, cur);
            end
         end
         MODE_TOKEN: begin
            scan_in_token(b, cur);
         end
         default: begin
            if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
               // Attribute shorthand; the digit then opens the next token.
               emit(KIND_ATTR, tok_start_q, 16'd1);
               mode_q    = MODE_SKIP;
               delim_q   = BYTE_SPACE;
               tok_len_q = 16'd0;
               bs_q      = 1'b0;
               scan_begin(b, cur);
            end else begin
               mode_q = MODE_TOKEN;
               scan_in_token(esc_q, cur);
               if (mode_q == MODE_SKIP) scan_begin(b, cur);
               else scan_in_token(b, cur);
            end
         end
      endcase
   endfunction

   function automatic void commit_step();
      out_word_type w;
      foreach (step_words[i]) begin
         w      = step_words[i];
         w.last = (i == step_words.size() - 1);
         expected_tokens.push_back(w);
      end
   endfunction

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'($urandom_range(1, 255));
      if (r < 3) return 8'(BYTE_DIGIT_0 + $urandom_range(0, 9));
      return 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic void push_keyword();
      int k;
      k = $urandom_range(0, 7);
      query_bytes.push_back(esc_q);
      for (int j = 0; j < kw_names[k].len(); j++) query_bytes.push_back(kw_names[k][j]);
      // Sometimes one more byte, mostly a near miss that then comes out as a plain term.
      if ($urandom_range(0, 4) == 0) query_bytes.push_back(word_char());
   endfunction

   // Mostly well-formed queries for the current configuration, with some noise.
   function automatic void build_queries(input int count);
      int         pick;
      int         n;
      bit         use_a;
      while (query_bytes.size() < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            query_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 30) begin
            push_keyword();
         end else if (pick < 40) begin
            query_bytes.push_back(esc_q);
            query_bytes.push_back(8'(BYTE_DIGIT_0 + $urandom_range(0, 9)));
         end else if (pick < 65) begin
            n = $urandom_range(1, 10);
            for (int j = 0; j < n; j++) begin
               if ($urandom_range(0, 9) == 0) begin
                  query_bytes.push_back(BYTE_BACKSLASH);
                  query_bytes.push_back(($urandom_range(0, 7) == 0) ?
                                        BYTE_NUL : 8'($urandom_range(1, 255)));
               end else begin
                  query_bytes.push_back(word_char());
               end
            end
         end else if (pick < 88) begin
            use_a = 1'($urandom_range(0, 1));
            query_bytes.push_back(use_a ? open_a_q : open_b_q);
            if ($urandom_range(0, 2) == 0) begin
               push_keyword();
            end else begin
               n = $urandom_range(0, 6);
               for (int j = 0; j < n; j++) begin
                  query_bytes.push_back(($urandom_range(0, 5) == 0) ?
                                        BYTE_SPACE : word_char());
               end
            end
            if ($urandom_range(0, 9) != 0) query_bytes.push_back(use_a ? close_a_q : close_b_q);
         end else begin
            query_bytes.push_back(BYTE_NUL);
         end
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
         for (int j = 0; j < n; j++) query_bytes.push_back(BYTE_SPACE);
      end
      query_bytes.push_back(BYTE_NUL);
   endfunction

   // The sender works in bursts with random gaps in between.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_queries();
      logic [7:0] b;
      while (query_bytes.size() != 0) begin
         b = query_bytes.pop_front();
         send_byte(b);
         predict_byte(b);
         commit_step();
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after the last write.
   task automatic write_csr(input csr_index_type idx, input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_ESC_BYTE:      esc_q = v;
         CSR_OPEN_QUOTE_A:  open_a_q = v;
         CSR_CLOSE_QUOTE_A: close_a_q = v;
         CSR_OPEN_QUOTE_B:  open_b_q = v;
         CSR_CLOSE_QUOTE_B: close_b_q = v;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [7:0] e, input logic [7:0] oa,
                                input logic [7:0] ca, input logic [7:0] ob,
                                input logic [7:0] cb);
      write_csr(CSR_ESC_BYTE, e);
      write_csr(CSR_OPEN_QUOTE_A, oa);
      write_csr(CSR_CLOSE_QUOTE_A, ca);
      write_csr(CSR_OPEN_QUOTE_B, ob);
      write_csr(CSR_CLOSE_QUOTE_B, cb);
      csr_we <= 1'b0;
   endtask

   task automatic run_queries(input logic [7:0] e, input logic [7:0] oa,
                              input logic [7:0] ca, input logic [7:0] ob,
                              input logic [7:0] cb);
      load_settings(e, oa, ca, ob, cb);
      build_queries(PHASE_BYTES);
      send_queries();
      drain();
   endtask

   function automatic void report_mismatch(input string what, input out_word_type want,
                                           input out_word_type got);
      string want_s;
      string got_s;
      error_count++;
      if (error_count <= 10) begin
         want_s = $sformatf("kind %0d start %0d len %0d last %0b",
                            want.kind, want.start, want.len, want.last);
         got_s  = $sformatf("kind %0d start %0d len %0d last %0b",
                            got.kind, got.start, got.len, got.last);
         $display("%s: expected %s, got %s", what, want_s, got_s);
      end
   endfunction

   always @(posedge clock) begin : token_checker
      out_word_type got;
      out_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{token_kind_type'(rsp_tuser), rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast};
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected word", '0, got);
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind != want.kind || got.start != want.start ||
                got.len != want.len || got.last != want.last) begin
               report_mismatch("word mismatch", want, got);
            end
         end
      end
      // The receiver periodically picks a new stall style at random.
      rx_cycle++;
      if (rx_cycle % 512 == 0) ready_style = $urandom_range(0, 3);
      case (ready_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rx_cycle % 3 != 0);
      endcase
   end

   initial begin
      directed_row_type row;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         send_byte(row.b);
         predict_byte(row.b);
         if (row.typed) begin
            step_words.delete();
            step_words.push_back(out_word_type'{row.k0, row.s0, row.l0, 1'b0});
            if (row.n == 2'd2) begin
               step_words.push_back(out_word_type'{row.k1, row.s1, row.l1, 1'b0});
            end
         end
         commit_step();
      end
      drain();

      run_queries(8'd64, 8'd123, 8'd125, 8'd34, 8'd34);

      // Escape of zero, and one byte that opens both separator pairs.
      run_queries(8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
      run_queries(8'd255, 8'd0, 8'd255, 8'd40, 8'd41);
      run_queries(BYTE_BACKSLASH, 8'd91, 8'd93, 8'd91, 8'd124);
      run_queries(BYTE_SPACE, 8'd60, 8'd62, 8'd39, 8'd39);
      run_queries(8'd34, 8'd123, 8'd34, 8'd34, 8'd125);
      for (int p = 0; p < 2; p++) begin
         run_queries(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
src/pqt_pkg.sv
src/prefix_query_tokenizer.sv
tb/sv/tb_top.sv
